[src/stnh_pkg.sv]
// ----------------------------------------------------------------------------
// stnh_pkg
// Shared types, widths and the multiply-accumulate step table of the
// segment/triangle nearest-hit core.
// ----------------------------------------------------------------------------
package stnh_pkg;

  // Field widths
  localparam int COORD_BITS    = 32;
  localparam int FRACTION_BITS = 16;
  localparam int FRAC_W        = FRACTION_BITS + 1;
  localparam int CFG_W         = 32;
  localparam int CFG_IDX_W     = 1;

  // Datapath widths: differences, cross products, multiplier operands, sums
  localparam int VEC_W  = COORD_BITS + 1;
  localparam int LONG_W = 2 * VEC_W + 1;
  localparam int LO_W   = VEC_W + 1;
  localparam int MUL_W  = LO_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = VEC_W + LONG_W + 4;

  localparam int DIV_CNT_W = $clog2(FRAC_W);
  localparam int STEP_W    = 6;

  localparam logic [FRAC_W-1:0] FRAC_ONE      = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [CFG_W-1:0]  DET_EPS_RESET = 32'd28147498;
  localparam logic [CFG_W-1:0]  MIN_LEN_RESET = 32'd43;

  // Step table bounds
  localparam logic [STEP_W-1:0] STEP_TRI_FIRST = 6'd0;
  localparam logic [STEP_W-1:0] STEP_TRI_LAST  = 6'd35;
  localparam logic [STEP_W-1:0] STEP_SEG_FIRST = 6'd36;
  localparam logic [STEP_W-1:0] STEP_SEG_LAST  = 6'd38;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DET_EPS,
    CFG_MIN_LEN
  } cfg_reg_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic   kind;
    coord_t p0_x;
    coord_t p0_y;
    coord_t p0_z;
    coord_t p1_x;
    coord_t p1_y;
    coord_t p1_z;
    coord_t p2_x;
    coord_t p2_y;
    coord_t p2_z;
    logic   last;
  } item_t;

  // Short operand vectors (A side)
  typedef enum logic [1:0] {SV_D, SV_E1, SV_E2, SV_S} svec_e;
  // Operand vectors for the B side, short or long
  typedef enum logic [2:0] {BV_D, BV_E1, BV_E2, BV_S, BV_P, BV_Q} bvec_e;
  // Where a finished sum goes
  typedef enum logic [2:0] {DST_NONE, DST_P, DST_Q, DST_DET, DST_U, DST_V, DST_T} dst_e;

  typedef struct packed {
    logic       valid;
    svec_e      a_vec;
    logic [1:0] a_idx;
    bvec_e      b_vec;
    logic [1:0] b_idx;
    logic       b_hi;
    logic       sub;
    logic       flip;
    logic       first;
    dst_e       dst;
    logic [1:0] dst_idx;
  } mac_op_t;

  typedef struct packed {
    logic    load;
    mac_op_t mac;
    logic    abs_det;
    logic    chk_sum;
    logic    chk_eval;
    logic    div_step;
    logic    update;
    logic    seg_check;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic degenerate;
    logic out_free;
  } status_t;

  function automatic mac_op_t mk(svec_e av, logic [1:0] ai, bvec_e bv, logic [1:0] bi,
                                 logic bh, logic sb, logic fl, logic fs,
                                 dst_e ds, logic [1:0] di);
    mac_op_t r;
    r.valid   = 1'b1;
    r.a_vec   = av;
    r.a_idx   = ai;
    r.b_vec   = bv;
    r.b_idx   = bi;
    r.b_hi    = bh;
    r.sub     = sb;
    r.flip    = fl;
    r.first   = fs;
    r.dst     = ds;
    r.dst_idx = di;
    return r;
  endfunction

  // One multiply-accumulate term per step:
  //   p = d x e2, q = s x e1, det = e1.p, U = s.p, V = d.q, T = e2.q,
  //   then the squared segment length d.d.
  function automatic mac_op_t mac_op(logic [STEP_W-1:0] step);
    mac_op_t r;
    r = '0;
    unique case (step)
      6'd0:  r = mk(SV_D,  2'd1, BV_E2, 2'd2, 1'b0, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
      6'd1:  r = mk(SV_D,  2'd2, BV_E2, 2'd1, 1'b0, 1'b1, 1'b0, 1'b0, DST_P,    2'd0);
      6'd2:  r = mk(SV_D,  2'd2, BV_E2, 2'd0, 1'b0, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
      6'd3:  r = mk(SV_D,  2'd0, BV_E2, 2'd2, 1'b0, 1'b1, 1'b0, 1'b0, DST_P,    2'd1);
      6'd4:  r = mk(SV_D,  2'd0, BV_E2, 2'd1, 1'b0, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
      6'd5:  r = mk(SV_D,  2'd1, BV_E2, 2'd0, 1'b0, 1'b1, 1'b0, 1'b0, DST_P,    2'd2);
      6'd6:  r = mk(SV_S,  2'd1, BV_E1, 2'd2, 1'b0, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
      6'd7:  r = mk(SV_S,  2'd2, BV_E1, 2'd1, 1'b0, 1'b1, 1'b0, 1'b0, DST_Q,    2'd0);
      6'd8:  r = mk(SV_S,  2'd2, BV_E1, 2'd0, 1'b0, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
      6'd9:  r = mk(SV_S,  2'd0, BV_E1, 2'd2, 1'b0, 1'b1, 1'b0, 1'b0, DST_Q,    2'd1);
      6'd10: r = mk(SV_S,  2'd0, BV_E1, 2'd1, 1'b0, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
      6'd11: r = mk(SV_S,  2'd1, BV_E1, 2'd0, 1'b0, 1'b1, 1'b0, 1'b0, DST_Q,    2'd2);
      6'd12: r = mk(SV_E1, 2'd0, BV_P,  2'd0, 1'b0, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
      6'd13: r = mk(SV_E1, 2'd0, BV_P,  2'd0, 1'b1, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      6'd14: r = mk(SV_E1, 2'd1, BV_P,  2'd1, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      6'd15: r = mk(SV_E1, 2'd1, BV_P,  2'd1, 1'b1, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      6'd16: r = mk(SV_E1, 2'd2, BV_P,  2'd2, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      6'd17: r = mk(SV_E1, 2'd2, BV_P,  2'd2, 1'b1, 1'b0, 1'b0, 1'b0, DST_DET,  2'd0);
      6'd18: r = mk(SV_S,  2'd0, BV_P,  2'd0, 1'b0, 1'b0, 1'b1, 1'b1, DST_NONE, 2'd0);
      6'd19: r = mk(SV_S,  2'd0, BV_P,  2'd0, 1'b1, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      6'd20: r = mk(SV_S,  2'd1, BV_P,  2'd1, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      6'd21: r = mk(SV_S,  2'd1, BV_P,  2'd1, 1'b1, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      6'd22: r = mk(SV_S,  2'd2, BV_P,  2'd2, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      6'd23: r = mk(SV_S,  2'd2, BV_P,  2'd2, 1'b1, 1'b0, 1'b1, 1'b0, DST_U,    2'd0);
      6'd24: r = mk(SV_D,  2'd0, BV_Q,  2'd0, 1'b0, 1'b0, 1'b1, 1'b1, DST_NONE, 2'd0);
      6'd25: r = mk(SV_D,  2'd0, BV_Q,  2'd0, 1'b1, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      6'd26: r = mk(SV_D,  2'd1, BV_Q,  2'd1, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      6'd27: r = mk(SV_D,  2'd1, BV_Q,  2'd1, 1'b1, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      6'd28: r = mk(SV_D,  2'd2, BV_Q,  2'd2, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      6'd29: r = mk(SV_D,  2'd2, BV_Q,  2'd2, 1'b1, 1'b0, 1'b1, 1'b0, DST_V,    2'd0);
      6'd30: r = mk(SV_E2, 2'd0, BV_Q,  2'd0, 1'b0, 1'b0, 1'b1, 1'b1, DST_NONE, 2'd0);
      6'd31: r = mk(SV_E2, 2'd0, BV_Q,  2'd0, 1'b1, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      6'd32: r = mk(SV_E2, 2'd1, BV_Q,  2'd1, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      6'd33: r = mk(SV_E2, 2'd1, BV_Q,  2'd1, 1'b1, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      6'd34: r = mk(SV_E2, 2'd2, BV_Q,  2'd2, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      6'd35: r = mk(SV_E2, 2'd2, BV_Q,  2'd2, 1'b1, 1'b0, 1'b1, 1'b0, DST_T,    2'd0);
      6'd36: r = mk(SV_D,  2'd0, BV_D,  2'd0, 1'b0, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
      6'd37: r = mk(SV_D,  2'd1, BV_D,  2'd1, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      6'd38: r = mk(SV_D,  2'd2, BV_D,  2'd2, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[src/stnh_if.sv]
// ----------------------------------------------------------------------------
// stnh channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface stnh_item_if import stnh_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   kind;
  coord_t p0_x;
  coord_t p0_y;
  coord_t p0_z;
  coord_t p1_x;
  coord_t p1_y;
  coord_t p1_z;
  coord_t p2_x;
  coord_t p2_y;
  coord_t p2_z;
  logic   last;

  modport source (output valid, kind, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
                  p2_x, p2_y, p2_z, last, input ready);
  modport sink   (input valid, kind, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
                  p2_x, p2_y, p2_z, last, output ready);
endinterface

interface stnh_result_if import stnh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [FRAC_W-1:0] fraction;

  modport source (output valid, hit, fraction, input ready);
  modport sink   (input valid, hit, fraction, output ready);
endinterface

interface stnh_cfg_if import stnh_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/stnh_ctrl.sv]
// ----------------------------------------------------------------------------
// stnh_ctrl
// Sequencer: walks the multiply-accumulate step table, then the checks,
// the bit-per-cycle division, the nearest update and the result hand-off.
// ----------------------------------------------------------------------------
module stnh_ctrl import stnh_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_kind_i,
  input  logic    in_last_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_MAC, S_DRAIN, S_ABS, S_CHK1, S_CHK2, S_DIV, S_UPD, S_SEGCHK, S_EMIT
  } state_e;

  state_e                 state_q;
  logic [STEP_W-1:0]      step_q;
  logic [DIV_CNT_W-1:0]   div_cnt_q;
  logic                   last_q;
  logic                   is_seg_q;
  logic [STEP_W-1:0]      step_end;

  assign step_end   = is_seg_q ? STEP_SEG_LAST : STEP_TRI_LAST;
  assign in_ready_o = (state_q == S_IDLE);

  // Decode commands from the current state
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:   cmd_o.load      = in_valid_i;
      S_MAC:    cmd_o.mac       = mac_op(step_q);
      S_DRAIN:  cmd_o           = '0;
      S_ABS:    cmd_o.abs_det   = 1'b1;
      S_CHK1:   cmd_o.chk_sum   = 1'b1;
      S_CHK2:   cmd_o.chk_eval  = 1'b1;
      S_DIV:    cmd_o.div_step  = 1'b1;
      S_UPD:    cmd_o.update    = 1'b1;
      S_SEGCHK: cmd_o.seg_check = 1'b1;
      S_EMIT:   cmd_o.emit      = status_i.out_free;
      default:  cmd_o           = '0;
    endcase
  end

  // Advance state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= '0;
      div_cnt_q <= '0;
      last_q    <= 1'b0;
      is_seg_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            last_q   <= in_last_i;
            is_seg_q <= !in_kind_i;
            if (!in_kind_i) begin
              step_q  <= STEP_SEG_FIRST;
              state_q <= S_MAC;
            end else if (status_i.degenerate) begin
              state_q <= in_last_i ? S_EMIT : S_IDLE;
            end else begin
              step_q  <= STEP_TRI_FIRST;
              state_q <= S_MAC;
            end
          end
        end
        S_MAC: begin
          if (step_q == step_end) begin
            state_q <= S_DRAIN;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_DRAIN:  state_q <= is_seg_q ? S_SEGCHK : S_ABS;
        S_ABS:    state_q <= S_CHK1;
        S_CHK1:   state_q <= S_CHK2;
        S_CHK2: begin
          div_cnt_q <= '0;
          state_q   <= S_DIV;
        end
        S_DIV: begin
          if (div_cnt_q == DIV_CNT_W'(FRACTION_BITS)) begin
            state_q <= S_UPD;
          end else begin
            div_cnt_q <= div_cnt_q + 1'b1;
          end
        end
        S_UPD:    state_q <= last_q ? S_EMIT : S_IDLE;
        S_SEGCHK: state_q <= last_q ? S_EMIT : S_IDLE;
        S_EMIT: begin
          if (status_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[src/stnh_datapath.sv]
// ----------------------------------------------------------------------------
// stnh_datapath
// Edge vectors, one shared multiplier with an accumulator, the hit checks,
// a restoring divider, the query state and the result register.
// ----------------------------------------------------------------------------
module stnh_datapath import stnh_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  item_t                item_i,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic                 cfg_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 out_hit_o,
  output logic [FRAC_W-1:0]    out_fraction_o
);

  typedef logic signed [VEC_W-1:0]  vec_t;
  typedef logic signed [LONG_W-1:0] long_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [MUL_W-1:0]  mul_t;

  // Configuration registers
  logic [CFG_W-1:0] det_eps_q;
  logic [CFG_W-1:0] min_len_q;

  // Segment state
  coord_t orig_q [3];
  vec_t   d_q    [3];
  logic   degen_q;
  logic   hit_q;
  logic [FRAC_W-1:0] nearest_q;

  // Triangle working set
  vec_t  e1_q [3];
  vec_t  e2_q [3];
  vec_t  s_q  [3];
  long_t p_q  [3];
  long_t q_q  [3];
  acc_t  det_q, u_q, v_q, t_q, uv_q, acc_q, rem_q;
  logic  det_neg_q;
  logic  ok_q;
  logic [FRAC_W-1:0] frac_q;

  // Multiplier pipeline
  logic signed [PROD_W-1:0] prod_q;
  mac_op_t                  s2_q;

  // Result register
  logic              out_valid_q;
  logic              out_hit_q;
  logic [FRAC_W-1:0] out_frac_q;

  coord_t in_a [3];
  coord_t in_b [3];
  coord_t in_c [3];

  mul_t  op_a, op_b;
  vec_t  a_vec, b_short;
  long_t b_long;
  acc_t  term, acc_base, acc_d;
  logic  term_neg;
  acc_t  det_cmp_eps;
  logic  rem_ge;
  acc_t  rem_nx;

  function automatic vec_t sel3(vec_t x0, vec_t x1, vec_t x2, logic [1:0] idx);
    vec_t r;
    case (idx)
      2'd1:    r = x1;
      2'd2:    r = x2;
      default: r = x0;
    endcase
    return r;
  endfunction

  function automatic long_t sel3l(long_t x0, long_t x1, long_t x2, logic [1:0] idx);
    long_t r;
    case (idx)
      2'd1:    r = x1;
      2'd2:    r = x2;
      default: r = x0;
    endcase
    return r;
  endfunction

  assign in_a = '{item_i.p0_x, item_i.p0_y, item_i.p0_z};
  assign in_b = '{item_i.p1_x, item_i.p1_y, item_i.p1_z};
  assign in_c = '{item_i.p2_x, item_i.p2_y, item_i.p2_z};

  // Select multiplier operands
  always_comb begin
    unique case (cmd_i.mac.a_vec)
      SV_D:    a_vec = sel3(d_q[0],  d_q[1],  d_q[2],  cmd_i.mac.a_idx);
      SV_E1:   a_vec = sel3(e1_q[0], e1_q[1], e1_q[2], cmd_i.mac.a_idx);
      SV_E2:   a_vec = sel3(e2_q[0], e2_q[1], e2_q[2], cmd_i.mac.a_idx);
      SV_S:    a_vec = sel3(s_q[0],  s_q[1],  s_q[2],  cmd_i.mac.a_idx);
      default: a_vec = '0;
    endcase
    b_short = '0;
    b_long  = '0;
    case (cmd_i.mac.b_vec)
      BV_D:    b_short = sel3(d_q[0],  d_q[1],  d_q[2],  cmd_i.mac.b_idx);
      BV_E1:   b_short = sel3(e1_q[0], e1_q[1], e1_q[2], cmd_i.mac.b_idx);
      BV_E2:   b_short = sel3(e2_q[0], e2_q[1], e2_q[2], cmd_i.mac.b_idx);
      BV_S:    b_short = sel3(s_q[0],  s_q[1],  s_q[2],  cmd_i.mac.b_idx);
      BV_P:    b_long  = sel3l(p_q[0], p_q[1],  p_q[2],  cmd_i.mac.b_idx);
      BV_Q:    b_long  = sel3l(q_q[0], q_q[1],  q_q[2],  cmd_i.mac.b_idx);
      default: b_short = '0;
    endcase
    op_a = MUL_W'(a_vec);
    if (cmd_i.mac.b_vec == BV_P || cmd_i.mac.b_vec == BV_Q) begin
      // long operand split: unsigned low part, signed high part
      if (cmd_i.mac.b_hi) begin
        op_b = MUL_W'($signed(b_long[LONG_W-1:LO_W]));
      end else begin
        op_b = $signed({1'b0, b_long[LO_W-1:0]});
      end
    end else begin
      op_b = MUL_W'(b_short);
    end
  end

  // Accumulate the registered product
  always_comb begin
    term     = s2_q.b_hi ? (ACC_W'(prod_q) <<< LO_W) : ACC_W'(prod_q);
    term_neg = s2_q.sub ^ (s2_q.flip & det_neg_q);
    acc_base = s2_q.first ? '0 : acc_q;
    acc_d    = term_neg ? (acc_base - term) : (acc_base + term);
  end

  assign det_cmp_eps = $signed({{(ACC_W-CFG_W){1'b0}}, det_eps_q});

  // Restoring division step
  always_comb begin
    rem_ge = (rem_q >= det_q);
    rem_nx = rem_ge ? (rem_q - det_q) : rem_q;
  end

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_eps_q <= DET_EPS_RESET;
      min_len_q <= MIN_LEN_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DET_EPS: det_eps_q <= cfg_data_i;
        CFG_MIN_LEN: min_len_q <= cfg_data_i;
        default:     det_eps_q <= det_eps_q;
      endcase
    end
  end

  // Query state and multiplier control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        orig_q[i] <= '0;
        d_q[i]    <= '0;
      end
      degen_q   <= 1'b1;
      hit_q     <= 1'b0;
      nearest_q <= FRAC_ONE;
      s2_q      <= '0;
      det_neg_q <= 1'b0;
      ok_q      <= 1'b0;
    end else begin
      s2_q <= cmd_i.mac;
      if (cmd_i.load && !item_i.kind) begin
        for (int i = 0; i < 3; i++) begin
          orig_q[i] <= in_a[i];
          d_q[i]    <= VEC_W'(in_b[i]) - VEC_W'(in_a[i]);
        end
        nearest_q <= FRAC_ONE;
        hit_q     <= 1'b0;
      end
      if (s2_q.valid && s2_q.dst == DST_DET) begin
        det_neg_q <= acc_d[ACC_W-1];
      end
      if (cmd_i.seg_check) begin
        degen_q <= (acc_q < $signed({{(ACC_W-CFG_W){1'b0}}, min_len_q}));
      end
      if (cmd_i.chk_eval) begin
        ok_q <= (det_q != '0) && !(det_q < det_cmp_eps)
             && !u_q[ACC_W-1] && !(det_q < u_q)
             && !v_q[ACC_W-1] && !(det_q < uv_q)
             && !t_q[ACC_W-1] && !(det_q < t_q);
      end
      if (cmd_i.update && ok_q && (frac_q < nearest_q)) begin
        nearest_q <= frac_q;
        hit_q     <= 1'b1;
      end
    end
  end

  // Working registers (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && item_i.kind) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= VEC_W'(in_b[i]) - VEC_W'(in_a[i]);
        e2_q[i] <= VEC_W'(in_c[i]) - VEC_W'(in_a[i]);
        s_q[i]  <= VEC_W'(orig_q[i]) - VEC_W'(in_a[i]);
      end
    end
    prod_q <= op_a * op_b;
    if (s2_q.valid) begin
      acc_q <= acc_d;
      for (int i = 0; i < 3; i++) begin
        if (s2_q.dst == DST_P && s2_q.dst_idx == 2'(i)) p_q[i] <= acc_d[LONG_W-1:0];
        if (s2_q.dst == DST_Q && s2_q.dst_idx == 2'(i)) q_q[i] <= acc_d[LONG_W-1:0];
      end
      if (s2_q.dst == DST_DET) det_q <= acc_d;
      if (s2_q.dst == DST_U)   u_q   <= acc_d;
      if (s2_q.dst == DST_V)   v_q   <= acc_d;
      if (s2_q.dst == DST_T)   t_q   <= acc_d;
    end
    if (cmd_i.abs_det && det_neg_q) det_q <= -det_q;
    if (cmd_i.chk_sum) uv_q <= u_q + v_q;
    if (cmd_i.chk_eval) begin
      rem_q  <= t_q;
      frac_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= rem_nx <<< 1;
      frac_q <= {frac_q[FRAC_W-2:0], rem_ge};
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_hit_q  <= hit_q;
      out_frac_q <= nearest_q;
    end
  end

  assign status_o.degenerate = degen_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign out_valid_o         = out_valid_q;
  assign out_hit_o           = out_hit_q;
  assign out_fraction_o      = out_frac_q;

endmodule

[src/segment_triangle_nearest_hit_core.sv]
// ----------------------------------------------------------------------------
// segment_triangle_nearest_hit_core
// Nearest segment/triangle hit over a streamed query of candidate triangles.
//
//   channel   dir  handshake      payload
//   item_i    in   valid/ready    kind, p0..p2 (x,y,z), last
//   result_o  out  valid/ready    hit, fraction
//   cfg_i     in   valid/ready    index, data (0 det_epsilon, 1 min_length_sq)
//
// A triangle item runs 36 terms through the one shared multiplier and then
// the bit-per-cycle divider; a triangle on a degenerate segment is consumed
// without computation. An item with last also loads the result register,
// which holds while the sink stalls; the next item is taken meanwhile,
// but a later last item waits, with the input held off, until that
// register is free.
// No clearing pass.
// ----------------------------------------------------------------------------
module segment_triangle_nearest_hit_core import stnh_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  stnh_item_if.sink      item_i,
  stnh_result_if.source  result_o,
  stnh_cfg_if.sink       cfg_i
);

  item_t   item;
  cmd_t    cmd;
  status_t status;

  // Gather the input fields
  always_comb begin
    item.kind = item_i.kind;
    item.p0_x = item_i.p0_x;
    item.p0_y = item_i.p0_y;
    item.p0_z = item_i.p0_z;
    item.p1_x = item_i.p1_x;
    item.p1_y = item_i.p1_y;
    item.p1_z = item_i.p1_z;
    item.p2_x = item_i.p2_x;
    item.p2_y = item_i.p2_y;
    item.p2_z = item_i.p2_z;
    item.last = item_i.last;
  end

  stnh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_kind_i  (item_i.kind),
    .in_last_i  (item_i.last),
    .in_ready_o (item_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  stnh_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .cfg_ready_o    (cfg_i.ready),
    .out_valid_o    (result_o.valid),
    .out_ready_i    (result_o.ready),
    .out_hit_o      (result_o.hit),
    .out_fraction_o (result_o.fraction)
  );

endmodule
